### rtl/assert_macros.svh
// Assertion macros for the RTL files; occupancy_grid_inflation_top uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property violated");

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

### rtl/ogi_pkg.sv
`default_nettype none
package ogi_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 15;

    localparam logic signed [7:0] OCC_LIMIT = 8'sd50;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CH  = $clog2(MAX_HEIGHT);
    localparam int EWW = $clog2(MAX_WIDTH + 1);
    localparam int EHW = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int OW  = RW + 1;
    localparam int XW  = ((CW > RW) ? CW : RW) + 2;
    localparam int YW  = ((CH > RW) ? CH : RW) + 2;
    localparam int D2W = 2 * RW + 9;

    localparam int STORE_BITS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_BITS);

    localparam int PAW = 5;
    localparam int RIW = PAW - 2;
    localparam int DW  = 32;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_MARK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [RIW-1:0] REG_MAP_WIDTH      = RIW'(0);
    localparam logic [RIW-1:0] REG_MAP_HEIGHT     = RIW'(1);
    localparam logic [RIW-1:0] REG_RADIUS_CELLS   = RIW'(2);
    localparam logic [RIW-1:0] REG_DISC_LIMIT_Q8  = RIW'(3);
    localparam logic [RIW-1:0] REG_MARKING_ENABLE = RIW'(4);

    typedef struct packed {
        logic [EWW-1:0] eff_w;
        logic [EHW-1:0] eff_h;
        logic [RW-1:0]  radius;
        logic [15:0]    limit;
        logic           enable;
    } t_geom;

    typedef struct packed {
        logic          in_map;
        logic          in_disc;
        logic [AW-1:0] addr;
    } t_unit_res;

endpackage
`default_nettype wire

### rtl/ogi_regs.sv
`default_nettype none
module ogi_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ogi_pkg::PAW-1:0]     paddr,
    input  logic [ogi_pkg::DW-1:0]      pwdata,
    output logic [ogi_pkg::DW-1:0]      prdata,
    output logic                        pready,
    output ogi_pkg::t_geom              o_geom
);

    logic [8:0]  r_map_width, n_map_width;
    logic [8:0]  r_map_height, n_map_height;
    logic [3:0]  r_radius_cells, n_radius_cells;
    logic [15:0] r_disc_limit_q8, n_disc_limit_q8;
    logic        r_marking_enable, n_marking_enable;

    logic                     wr;
    logic [ogi_pkg::RIW-1:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ogi_pkg::PAW-1:2];

    always_comb begin
        n_map_width      = r_map_width;
        n_map_height     = r_map_height;
        n_radius_cells   = r_radius_cells;
        n_disc_limit_q8  = r_disc_limit_q8;
        n_marking_enable = r_marking_enable;
        if (wr) begin
            case (idx)
                ogi_pkg::REG_MAP_WIDTH:      n_map_width      = pwdata[8:0];
                ogi_pkg::REG_MAP_HEIGHT:     n_map_height     = pwdata[8:0];
                ogi_pkg::REG_RADIUS_CELLS:   n_radius_cells   = pwdata[3:0];
                ogi_pkg::REG_DISC_LIMIT_Q8:  n_disc_limit_q8  = pwdata[15:0];
                ogi_pkg::REG_MARKING_ENABLE: n_marking_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width      <= 9'd0;
            r_map_height     <= 9'd0;
            r_radius_cells   <= 4'd3;
            r_disc_limit_q8  <= 16'd2304;
            r_marking_enable <= 1'b0;
        end else begin
            r_map_width      <= n_map_width;
            r_map_height     <= n_map_height;
            r_radius_cells   <= n_radius_cells;
            r_disc_limit_q8  <= n_disc_limit_q8;
            r_marking_enable <= n_marking_enable;
        end
    end

    always_comb begin
        case (idx)
            ogi_pkg::REG_MAP_WIDTH:      prdata = ogi_pkg::DW'(r_map_width);
            ogi_pkg::REG_MAP_HEIGHT:     prdata = ogi_pkg::DW'(r_map_height);
            ogi_pkg::REG_RADIUS_CELLS:   prdata = ogi_pkg::DW'(r_radius_cells);
            ogi_pkg::REG_DISC_LIMIT_Q8:  prdata = ogi_pkg::DW'(r_disc_limit_q8);
            ogi_pkg::REG_MARKING_ENABLE: prdata = ogi_pkg::DW'(r_marking_enable);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        o_geom.eff_w  = (int'(r_map_width) > ogi_pkg::MAX_WIDTH)
                      ? ogi_pkg::EWW'(ogi_pkg::MAX_WIDTH) : ogi_pkg::EWW'(r_map_width);
        o_geom.eff_h  = (int'(r_map_height) > ogi_pkg::MAX_HEIGHT)
                      ? ogi_pkg::EHW'(ogi_pkg::MAX_HEIGHT) : ogi_pkg::EHW'(r_map_height);
        o_geom.radius = (int'(r_radius_cells) > ogi_pkg::MAX_RADIUS)
                      ? ogi_pkg::RW'(ogi_pkg::MAX_RADIUS) : ogi_pkg::RW'(r_radius_cells);
        o_geom.limit  = r_disc_limit_q8;
        o_geom.enable = r_marking_enable;
    end

endmodule
`default_nettype wire

### rtl/ogi_unit.sv
`default_nettype none
module ogi_unit (
    input  logic [ogi_pkg::CW-1:0]        i_x,
    input  logic [ogi_pkg::CH-1:0]        i_y,
    input  logic signed [ogi_pkg::OW-1:0] i_dx,
    input  logic signed [ogi_pkg::OW-1:0] i_dy,
    input  ogi_pkg::t_geom                i_geom,
    output ogi_pkg::t_unit_res            o_res
);

    localparam int PW = ogi_pkg::CH + ogi_pkg::EWW;

    logic signed [ogi_pkg::XW-1:0]  nx;
    logic signed [ogi_pkg::YW-1:0]  ny;
    logic [ogi_pkg::RW-1:0]         adx, ady;
    logic signed [ogi_pkg::OW-1:0]  ndx, ndy;
    logic [2*ogi_pkg::RW-1:0]       sqx, sqy;
    logic [2*ogi_pkg::RW:0]         sqsum;
    logic [ogi_pkg::D2W-1:0]        d2;
    logic [PW-1:0]                  prod;
    logic [PW:0]                    sum;

    always_comb begin
        nx  = $signed({{(ogi_pkg::XW - ogi_pkg::CW){1'b0}}, i_x}) + ogi_pkg::XW'(i_dx);
        ny  = $signed({{(ogi_pkg::YW - ogi_pkg::CH){1'b0}}, i_y}) + ogi_pkg::YW'(i_dy);
        o_res.in_map = !nx[ogi_pkg::XW-1] && (nx[ogi_pkg::XW-2:0] < i_geom.eff_w)
                    && !ny[ogi_pkg::YW-1] && (ny[ogi_pkg::YW-2:0] < i_geom.eff_h);

        ndx   = -i_dx;
        ndy   = -i_dy;
        adx   = i_dx[ogi_pkg::OW-1] ? ndx[ogi_pkg::RW-1:0] : i_dx[ogi_pkg::RW-1:0];
        ady   = i_dy[ogi_pkg::OW-1] ? ndy[ogi_pkg::RW-1:0] : i_dy[ogi_pkg::RW-1:0];
        sqx   = (2 * ogi_pkg::RW)'(adx) * (2 * ogi_pkg::RW)'(adx);
        sqy   = (2 * ogi_pkg::RW)'(ady) * (2 * ogi_pkg::RW)'(ady);
        sqsum = {1'b0, sqx} + {1'b0, sqy};
        d2    = {sqsum, 8'd0};
        o_res.in_disc = (d2 <= i_geom.limit);

        prod = PW'(ny[ogi_pkg::CH-1:0]) * PW'(i_geom.eff_w);
        sum  = {1'b0, prod} + (PW + 1)'(nx[ogi_pkg::CW-1:0]);
        o_res.addr = sum[ogi_pkg::AW-1:0];
    end

endmodule
`default_nettype wire

### rtl/occupancy_grid_inflation_top.sv
// The result strobe follows straight from S_IDLE for a skipped mark, a query outside the map
// and the unused mode; a query inside the map passes S_QADDR and S_QDATA first; a mark walks
// every offset of the (2R+1) by (2R+1) square around the cell, with R the radius, and then
// S_DRAIN; a clear passes over every store cell. The store port writes one cell per cycle.
// A new transaction can be taken at the edge that ends the strobe, and not before; the receiver cannot stall.
// After reset the store is cleared in a pass over every cell with busy high; writes are taken.
`default_nettype none
`include "assert_macros.svh"
module occupancy_grid_inflation_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_mode,
    input  logic signed [15:0]         i_cell_x,
    input  logic signed [15:0]         i_cell_y,
    input  logic signed [7:0]          i_occupancy,
    output logic                       o_done,
    output logic                       o_blocked,
    output logic [1:0]                 o_done_mode,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ogi_pkg::PAW-1:0]    paddr,
    input  logic [ogi_pkg::DW-1:0]     pwdata,
    output logic [ogi_pkg::DW-1:0]     prdata,
    output logic                       pready
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_QADDR = 3'd5;
    localparam logic [2:0] S_QDATA = 3'd6;

    ogi_pkg::t_geom     geom;
    ogi_pkg::t_unit_res u_res;

    logic [2:0]                     r_state, n_state;
    logic [ogi_pkg::AW-1:0]         r_clr_addr, n_clr_addr;
    logic                           r_wr_en, n_wr_en;
    logic                           r_done, n_done;
    logic [ogi_pkg::AW-1:0]         r_wr_addr, n_wr_addr;
    logic [ogi_pkg::CW-1:0]         r_x, n_x;
    logic [ogi_pkg::CH-1:0]         r_y, n_y;
    logic signed [ogi_pkg::OW-1:0]  r_dx, n_dx;
    logic signed [ogi_pkg::OW-1:0]  r_dy, n_dy;
    logic                           r_blocked, n_blocked;
    logic [1:0]                     r_done_mode, n_done_mode;
    logic                           r_rd_data;
    logic                           r_map [ogi_pkg::STORE_BITS];

    logic                           cell_ok, occ_ok, mark_ok;
    logic signed [ogi_pkg::OW-1:0]  pos_r, neg_r;
    logic                           w_en, w_val;
    logic [ogi_pkg::AW-1:0]         w_addr;

    ogi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    ogi_unit u_unit (
        .i_x    (r_x),
        .i_y    (r_y),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .i_geom (geom),
        .o_res  (u_res)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_blocked   = r_blocked;
    assign o_done_mode = r_done_mode;

    assign pos_r   = $signed({1'b0, geom.radius});
    assign neg_r   = -pos_r;
    assign cell_ok = !i_cell_x[15] && (i_cell_x[14:0] < geom.eff_w)
                  && !i_cell_y[15] && (i_cell_y[14:0] < geom.eff_h);
    assign occ_ok  = i_occupancy[7] || (i_occupancy >= ogi_pkg::OCC_LIMIT);
    assign mark_ok = geom.enable && cell_ok && occ_ok;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_wr_en     = 1'b0;
        n_done      = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_x         = r_x;
        n_y         = r_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_blocked   = r_blocked;
        n_done_mode = r_done_mode;
        case (r_state)
            S_INIT: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_done_mode = i_mode;
                    n_blocked   = 1'b0;
                    n_x         = i_cell_x[ogi_pkg::CW-1:0];
                    n_y         = i_cell_y[ogi_pkg::CH-1:0];
                    n_dx        = (i_mode == ogi_pkg::MODE_QUERY) ? '0 : neg_r;
                    n_dy        = (i_mode == ogi_pkg::MODE_QUERY) ? '0 : neg_r;
                    case (i_mode)
                        ogi_pkg::MODE_CLEAR: n_state = S_CLEAR;
                        ogi_pkg::MODE_MARK: begin
                            if (mark_ok) begin
                                n_state = S_WALK;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        ogi_pkg::MODE_QUERY: begin
                            if (cell_ok) begin
                                n_state = S_QADDR;
                            end else begin
                                n_done    = 1'b1;
                                n_blocked = 1'b1;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_WALK: begin
                n_wr_en   = u_res.in_map && u_res.in_disc;
                n_wr_addr = u_res.addr;
                if (r_dx == pos_r) begin
                    n_dx = neg_r;
                    if (r_dy == pos_r) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_dy = r_dy + ogi_pkg::OW'(1);
                    end
                end else begin
                    n_dx = r_dx + ogi_pkg::OW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_QADDR: n_state = S_QDATA;
            S_QDATA: begin
                n_blocked = r_rd_data;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_clr_addr <= '0;
            r_wr_en    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_wr_en    <= n_wr_en;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr   <= n_wr_addr;
        r_x         <= n_x;
        r_y         <= n_y;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_blocked   <= n_blocked;
        r_done_mode <= n_done_mode;
    end

    always_comb begin
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_val  = 1'b0;
        end else begin
            w_en   = r_wr_en;
            w_addr = r_wr_addr;
            w_val  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_map[w_addr] <= w_val;
        end
        r_rd_data <= r_map[u_res.addr];
    end

    `ASSERT_CLK(a_accept_progress, i_clk, i_rst_n, (start && !busy) |=> (busy || r_done))
    `ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, r_done && busy)
    `ASSERT_CLK(a_write_in_walk, i_clk, i_rst_n,
        r_wr_en |-> (r_state == S_WALK || r_state == S_DRAIN))
    `ASSERT_CLK(a_blocked_query_only, i_clk, i_rst_n,
        (r_done && (r_done_mode != ogi_pkg::MODE_QUERY)) |-> !r_blocked)

endmodule
`default_nettype wire

### sim/occupancy_grid_inflation_top_test.sv
`default_nettype none
module occupancy_grid_inflation_top_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 300000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [7:0]  occ;
    } t_grid_cmd;

    typedef struct packed {
        logic       blocked;
        logic [1:0] mode;
    } t_grid_answer;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  i_mode = '0;
    logic signed [15:0]          i_cell_x = '0;
    logic signed [15:0]          i_cell_y = '0;
    logic signed [7:0]           i_occupancy = '0;
    logic                        o_done;
    logic                        o_blocked;
    logic [1:0]                  o_done_mode;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ogi_pkg::PAW-1:0]     paddr = '0;
    logic [ogi_pkg::DW-1:0]      pwdata = '0;
    logic [ogi_pkg::DW-1:0]      prdata;
    logic                        pready;

    occupancy_grid_inflation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .i_occupancy (i_occupancy),
        .o_done      (o_done),
        .o_blocked   (o_blocked),
        .o_done_mode (o_done_mode),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bit           blocked_store [ogi_pkg::STORE_BITS];
    int unsigned  grid_w = 0;
    int unsigned  grid_h = 0;
    int unsigned  grid_r = 3;
    int unsigned  grid_limit = 2304;
    bit           grid_marking = 1'b0;

    t_grid_cmd    pending_cmds [$];
    t_grid_answer expected_answers [$];
    t_grid_cmd    next_cmd;
    t_grid_cmd    taken_cmd;
    t_grid_answer oldest_answer;
    t_grid_answer fresh_answer;
    int unsigned  queued_total = 0;
    int unsigned  answered_total = 0;
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;
    bit           gaps_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int span_w();
        return (grid_w > ogi_pkg::MAX_WIDTH) ? ogi_pkg::MAX_WIDTH : grid_w;
    endfunction

    function automatic int span_h();
        return (grid_h > ogi_pkg::MAX_HEIGHT) ? ogi_pkg::MAX_HEIGHT : grid_h;
    endfunction

    function automatic bit on_map(int x, int y);
        return x >= 0 && x < span_w() && y >= 0 && y < span_h();
    endfunction

    // Applies one command to the shadow grid and returns the answer it must produce.
    function automatic t_grid_answer grid_apply(t_grid_cmd c);
        t_grid_answer a;
        int r;
        int dx;
        int dy;
        a.blocked = 1'b0;
        a.mode = c.mode;
        case (c.mode)
            ogi_pkg::MODE_CLEAR: begin
                foreach (blocked_store[i]) blocked_store[i] = 1'b0;
            end
            ogi_pkg::MODE_MARK: begin
                if (grid_marking && on_map(c.x, c.y)
                        && (c.occ < 0 || c.occ >= ogi_pkg::OCC_LIMIT)) begin
                    r = (grid_r > ogi_pkg::MAX_RADIUS) ? ogi_pkg::MAX_RADIUS : grid_r;
                    for (dy = -r; dy <= r; dy++) begin
                        for (dx = -r; dx <= r; dx++) begin
                            if ((dx * dx + dy * dy) * 256 <= grid_limit
                                    && on_map(c.x + dx, c.y + dy)) begin
                                blocked_store[(c.y + dy) * span_w() + c.x + dx] = 1'b1;
                            end
                        end
                    end
                end
            end
            ogi_pkg::MODE_QUERY: begin
                a.blocked = on_map(c.x, c.y) ? blocked_store[c.y * span_w() + c.x] : 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic bit sender_pause();
        return gaps_on && ($urandom_range(99) < 10);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if ((!start || !busy) && pending_cmds.size() != 0 && !sender_pause()) begin
            next_cmd = pending_cmds.pop_front();
            start <= 1'b1;
            i_mode <= next_cmd.mode;
            i_cell_x <= next_cmd.x;
            i_cell_y <= next_cmd.y;
            i_occupancy <= next_cmd.occ;
        end else if (!busy) begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got blocked=%0d mode=%0d",
                             $time, o_blocked, o_done_mode);
                    mismatches++;
                end else begin
                    oldest_answer = expected_answers.pop_front();
                    if (o_blocked !== oldest_answer.blocked) begin
                        $display("%0t: blocked mismatch: expected %0d, got %0d",
                                 $time, oldest_answer.blocked, o_blocked);
                        mismatches++;
                    end
                    if (o_done_mode !== oldest_answer.mode) begin
                        $display("%0t: done_mode mismatch: expected %0d, got %0d",
                                 $time, oldest_answer.mode, o_done_mode);
                        mismatches++;
                    end
                end
                answered_total++;
            end
            if (start && !busy) begin
                taken_cmd = {i_mode, i_cell_x, i_cell_y, i_occupancy};
                fresh_answer = grid_apply(taken_cmd);
                expected_answers = {expected_answers, fresh_answer};
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(logic [1:0] mode, int x, int y, int occ);
        t_grid_cmd c;
        c.mode = mode;
        c.x = 16'(x);
        c.y = 16'(y);
        c.occ = 8'(occ);
        pending_cmds = {pending_cmds, c};
        queued_total++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || answered_total < queued_total || busy);
    endtask

    task automatic write_reg(logic [ogi_pkg::RIW-1:0] idx, int unsigned value);
        logic [ogi_pkg::DW-1:0] mask;
        case (idx)
            ogi_pkg::REG_MAP_WIDTH, ogi_pkg::REG_MAP_HEIGHT: mask = 'h1FF;
            ogi_pkg::REG_RADIUS_CELLS:                       mask = 'hF;
            ogi_pkg::REG_DISC_LIMIT_Q8:                      mask = 'hFFFF;
            default:                                         mask = 'h1;
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            ogi_pkg::REG_MAP_WIDTH:     grid_w = value & mask;
            ogi_pkg::REG_MAP_HEIGHT:    grid_h = value & mask;
            ogi_pkg::REG_RADIUS_CELLS:  grid_r = value & mask;
            ogi_pkg::REG_DISC_LIMIT_Q8: grid_limit = value & mask;
            default:                    grid_marking = 1'(value & mask);
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== (value & mask)) begin
            $display("%0t: register %0d readback mismatch: expected %0d, got %0d",
                     $time, idx, value & mask, prdata);
            mismatches++;
        end
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(int unsigned w, int unsigned h, int unsigned r,
                            int unsigned lim, int unsigned en);
        write_reg(ogi_pkg::REG_MAP_WIDTH, w);
        write_reg(ogi_pkg::REG_MAP_HEIGHT, h);
        write_reg(ogi_pkg::REG_RADIUS_CELLS, r);
        write_reg(ogi_pkg::REG_DISC_LIMIT_Q8, lim);
        write_reg(ogi_pkg::REG_MARKING_ENABLE, en);
    endtask

    // Most commands land on or near the map so that marks and queries interact;
    // the rest carry random coordinates and occupancy and a random mode other than clear.
    task automatic random_phase(int count, int mark_pct);
        int i;
        int pick;
        int margin;
        int x;
        int y;
        int occ;
        margin = grid_r + 2;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_cmd(2'($urandom_range(3, 1)), $urandom, $urandom, $urandom);
            end else begin
                x = int'($urandom_range(span_w() + 2 * margin)) - margin;
                y = int'($urandom_range(span_h() + 2 * margin)) - margin;
                if (pick < 10 + mark_pct) begin
                    case ($urandom_range(3))
                        0:       occ = $urandom;
                        1:       occ = -int'($urandom_range(128, 1));
                        default: occ = $urandom_range(127, 50);
                    endcase
                    send_cmd(ogi_pkg::MODE_MARK, x, y, occ);
                end else begin
                    send_cmd(ogi_pkg::MODE_QUERY, x, y, $urandom);
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(ogi_pkg::MODE_QUERY, 0, 0, 0);
        send_cmd(ogi_pkg::MODE_MARK, 0, 0, 100);
        send_cmd(ogi_pkg::MODE_QUERY, -32768, -32768, 0);
        send_cmd(MODE_UNUSED, 32767, 32767, 127);
        wait_drained();

        set_grid(16, 12, 3, 2304, 1);
        send_cmd(ogi_pkg::MODE_MARK, 0, 0, -128);
        send_cmd(ogi_pkg::MODE_MARK, 15, 11, 127);
        send_cmd(ogi_pkg::MODE_MARK, 8, 6, 50);
        send_cmd(ogi_pkg::MODE_MARK, 3, 9, 49);
        send_cmd(ogi_pkg::MODE_MARK, 12, 2, 0);
        send_cmd(ogi_pkg::MODE_MARK, -1, 5, 100);
        send_cmd(ogi_pkg::MODE_MARK, 16, 0, 100);
        send_cmd(ogi_pkg::MODE_MARK, 0, 12, -1);
        send_cmd(ogi_pkg::MODE_QUERY, 0, 0, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 3, 0, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 2, 2, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 3, 3, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 3, 9, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 12, 2, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 16, 11, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 15, 12, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 32767, -32768, -128);
        send_cmd(ogi_pkg::MODE_QUERY, -32768, 32767, 127);
        send_cmd(MODE_UNUSED, -1, -1, -1);
        send_cmd(ogi_pkg::MODE_CLEAR, 0, 0, 0);
        send_cmd(ogi_pkg::MODE_QUERY, 0, 0, 0);
        wait_drained();

        set_grid(256, 256, 15, 57600, 1);
        send_cmd(ogi_pkg::MODE_CLEAR, 0, 0, 0);
        random_phase(110, 15);

        set_grid(300, 511, 2, 65535, 1);
        random_phase(110, 35);

        set_grid(8, 8, 0, 0, 1);
        send_cmd(ogi_pkg::MODE_CLEAR, 0, 0, 0);
        random_phase(110, 35);

        set_grid(1, 200, 4, 1024, 1);
        random_phase(110, 35);

        set_grid(37, 5, 1, 256, 0);
        random_phase(110, 35);

        set_grid(0, 10, 5, 4000, 1);
        random_phase(110, 35);

        set_grid(64, 48, 3, 2304, 1);
        gaps_on = 1'b0;
        send_cmd(ogi_pkg::MODE_CLEAR, 0, 0, 0);
        random_phase(110, 35);
        gaps_on = 1'b1;

        set_grid(20, 30, 7, 12544, 1);
        random_phase(110, 35);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/ogi_pkg.sv
rtl/ogi_regs.sv
rtl/ogi_unit.sv
rtl/occupancy_grid_inflation_top.sv
sim/occupancy_grid_inflation_top_test.sv
